// ===== design/plmon_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, field widths and codes of the probe loss and delay monitor.
package plmon_pkg;

  localparam int SeqW     = 31;
  localparam int DlyW     = 24;
  localparam int SumOutW  = 29;
  localparam int LostOutW = 4;
  localparam int LimitW   = 16;
  localparam int PctW     = 7;
  localparam int CntW     = 32;
  localparam int AddrW    = 5;
  localparam int DataW    = 32;

  typedef enum logic {
    OpSent  = 1'b0,
    OpReply = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    RegDownLimit = 3'd0,
    RegDelayHigh = 3'd1,
    RegDelayLow  = 3'd2,
    RegLossHigh  = 3'd3,
    RegLossLow   = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [LimitW-1:0] down_limit;
    logic [DlyW-1:0]   delay_high;
    logic [DlyW-1:0]   delay_low;
    logic [PctW-1:0]   loss_high;
    logic [PctW-1:0]   loss_low;
  } cfg_t;

  // Per-event context computed at transfer time and carried to the update stage.
  typedef struct packed {
    op_e             op;
    logic            ans_clr;      // sent: clear the new probe's answered mark
    logic            drop_chk;     // sent: oldest probe leaves the ring
    logic            age_chk;      // sent: a probe enters the loss window
    logic            raise_ok;     // sent: loss alarm may rise
    logic            down_trip;    // sent: unanswered count above limit
    logic            reply_hit;    // reply: sequence lies in the ring
    logic            reply_aged;   // reply: probe already inside the loss window
    logic            clear_ok;     // reply: loss alarm may clear
    logic            delay_armed;  // reply: enough replies for the delay alarm
    logic            ring_empty;   // reply: delay slot never written
    logic [SeqW-1:0] probe_seq;
    logic [DlyW-1:0] delay_us;
  } ctx_t;

  typedef struct packed {
    logic active;
    logic changed;
  } alarm_t;

endpackage

// ===== design/plmon_cfg.sv =====
`timescale 1ns / 1ps
// APB register file holding the alarm thresholds.
module plmon_cfg
  import plmon_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  cfg_t cfg_q;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      case (paddr[4:2])
        RegDownLimit: cfg_q.down_limit <= pwdata[LimitW-1:0];
        RegDelayHigh: cfg_q.delay_high <= pwdata[DlyW-1:0];
        RegDelayLow:  cfg_q.delay_low  <= pwdata[DlyW-1:0];
        RegLossHigh:  cfg_q.loss_high  <= pwdata[PctW-1:0];
        RegLossLow:   cfg_q.loss_low   <= pwdata[PctW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      RegDownLimit: prdata = DataW'(cfg_q.down_limit);
      RegDelayHigh: prdata = DataW'(cfg_q.delay_high);
      RegDelayLow:  prdata = DataW'(cfg_q.delay_low);
      RegLossHigh:  prdata = DataW'(cfg_q.loss_high);
      RegLossLow:   prdata = DataW'(cfg_q.loss_low);
      default:      prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ===== design/plmon_front.sv =====
`timescale 1ns / 1ps
// Front stage: probe and reply counters, ring addresses and per-event flags.
module plmon_front
  import plmon_pkg::*;
#(
  parameter int DELAY_WINDOW = 20,
  parameter int LOSS_HOLDOFF = 3,
  parameter int LOSS_WINDOW  = 10,
  localparam int Ring   = LOSS_HOLDOFF + LOSS_WINDOW,
  localparam int PtrW   = $clog2(Ring),
  localparam int DSlotW = $clog2(DELAY_WINDOW)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic              operation_i,
  input  logic [SeqW-1:0]   reply_seq_i,
  input  logic [DlyW-1:0]   delay_us_i,
  input  cfg_t              cfg_i,
  output ctx_t              ctx_o,
  output logic [PtrW-1:0]   ans_addr_a_o,
  output logic [PtrW-1:0]   ans_addr_b_o,
  output logic [DSlotW-1:0] dly_addr_o
);

  localparam logic [CntW-1:0] RingC   = CntW'(Ring);
  localparam logic [CntW-1:0] Ring1C  = CntW'(Ring + 1);
  localparam logic [CntW-1:0] HoldC   = CntW'(LOSS_HOLDOFF);
  localparam logic [CntW-1:0] WinC    = CntW'(DELAY_WINDOW);
  localparam logic [SeqW-1:0] RingS   = SeqW'(Ring);
  localparam logic [SeqW-1:0] HoldS   = SeqW'(LOSS_HOLDOFF);
  localparam logic [PtrW:0]   RingP   = (PtrW+1)'(Ring);
  localparam logic [PtrW:0]   RingM1P = (PtrW+1)'(Ring - 1);
  localparam logic [PtrW:0]   HoldP   = (PtrW+1)'(LOSS_HOLDOFF);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Ring - 1);
  localparam logic [DSlotW-1:0] LastSlot = DSlotW'(DELAY_WINDOW - 1);

  logic [CntW-1:0]   sent_q, sent_d;
  logic [CntW-1:0]   highest_q, highest_d;
  logic [CntW-1:0]   rcount_q, rcount_d;
  logic [PtrW-1:0]   ptr_q, ptr_d;
  logic [DSlotW-1:0] dslot_q, dslot_d;
  logic              wrapped_q, wrapped_d;

  logic              is_reply;
  logic [CntW-1:0]   sent_inc, sent_new, seq_next, rc_inc, unans;
  logic [SeqW-1:0]   seq_age;
  logic              sent_last;
  logic [PtrW:0]     idx_sum, b_sum;
  logic [PtrW-1:0]   reply_idx, aged_idx;

  assign is_reply  = (op_e'(operation_i) == OpReply);
  assign sent_inc  = sent_q + CntW'(1);
  assign sent_last = (sent_q == '1);
  assign sent_new  = is_reply ? sent_q : sent_inc;
  assign seq_next  = {1'b0, reply_seq_i} + CntW'(1);
  assign rc_inc    = (rcount_q == '1) ? rcount_q : rcount_q + CntW'(1);
  assign unans     = sent_inc - highest_q;

  // Age of the answered probe, counted back from the latest one.
  assign seq_age   = SeqW'(sent_q - CntW'(1) - {1'b0, reply_seq_i});
  assign idx_sum   = {1'b0, ptr_q} + RingM1P - (PtrW+1)'(seq_age[PtrW-1:0]);
  assign reply_idx = (idx_sum >= RingP) ? PtrW'(idx_sum - RingP) : PtrW'(idx_sum);
  assign b_sum     = {1'b0, ptr_q} + RingP - HoldP;
  assign aged_idx  = (b_sum >= RingP) ? PtrW'(b_sum - RingP) : PtrW'(b_sum);

  assign ans_addr_a_o = is_reply ? reply_idx : ptr_q;
  assign ans_addr_b_o = aged_idx;
  assign dly_addr_o   = dslot_q;

  always_comb begin
    ctx_o             = '0;
    ctx_o.op          = op_e'(operation_i);
    ctx_o.drop_chk    = (sent_q >= RingC);
    ctx_o.ans_clr     = (sent_q >= RingC) || !wrapped_q;
    ctx_o.age_chk     = (sent_q >= HoldC);
    ctx_o.raise_ok    = (sent_q > RingC);
    ctx_o.down_trip   = (cfg_i.down_limit != '0) && (sent_inc > highest_q) &&
                        (unans > CntW'(cfg_i.down_limit));
    ctx_o.reply_hit   = (sent_q != '0) && (seq_age < RingS) && ({1'b0, seq_age} < sent_q);
    ctx_o.reply_aged  = (seq_age >= HoldS);
    ctx_o.clear_ok    = (sent_q > Ring1C);
    ctx_o.delay_armed = (rc_inc > WinC);
    ctx_o.ring_empty  = (rcount_q < WinC);
    ctx_o.probe_seq   = (sent_new == '0) ? '0 : SeqW'(sent_new - CntW'(1));
    ctx_o.delay_us    = delay_us_i;
  end

  always_comb begin
    sent_d    = sent_q;
    highest_d = highest_q;
    rcount_d  = rcount_q;
    ptr_d     = ptr_q;
    dslot_d   = dslot_q;
    wrapped_d = wrapped_q;
    if (accept_i) begin
      if (is_reply) begin
        if (seq_next > highest_q) highest_d = seq_next;
        rcount_d = rc_inc;
        dslot_d  = (dslot_q == LastSlot) ? '0 : dslot_q + DSlotW'(1);
      end else begin
        sent_d = sent_inc;
        // the ring slot follows the counter, restarting when it wraps
        ptr_d  = (ptr_q == LastPtr || sent_last) ? '0 : ptr_q + PtrW'(1);
        if (sent_last) wrapped_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sent_q    <= '0;
      highest_q <= '0;
      rcount_q  <= '0;
      ptr_q     <= '0;
      dslot_q   <= '0;
      wrapped_q <= 1'b0;
    end else begin
      sent_q    <= sent_d;
      highest_q <= highest_d;
      rcount_q  <= rcount_d;
      ptr_q     <= ptr_d;
      dslot_q   <= dslot_d;
      wrapped_q <= wrapped_d;
    end
  end

endmodule

// ===== design/plmon_loss.sv =====
`timescale 1ns / 1ps
// Answered-mark memory, lost probe count and loss alarm.
module plmon_loss
  import plmon_pkg::*;
#(
  parameter int LOSS_HOLDOFF = 3,
  parameter int LOSS_WINDOW  = 10,
  localparam int Ring  = LOSS_HOLDOFF + LOSS_WINDOW,
  localparam int PtrW  = $clog2(Ring),
  localparam int LostW = $clog2(LOSS_WINDOW + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic                advance_i,
  input  logic [PtrW-1:0]     addr_a_i,
  input  logic [PtrW-1:0]     addr_b_i,
  input  ctx_t                ctx_i,
  input  cfg_t                cfg_i,
  output logic [LostOutW-1:0] lost_o,
  output alarm_t              alarm_o
);

  localparam int ProdW = LostW + PctW;
  localparam logic [LostW-1:0] LossWin = LostW'(LOSS_WINDOW);
  localparam logic [ProdW-1:0] Pct100  = ProdW'(100);
  localparam logic [ProdW-1:0] WinP    = ProdW'(LOSS_WINDOW);

  logic             mark_q [Ring];
  logic             rd_a_q, rd_b_q;
  logic             hit_a_q, hit_b_q, fwd_q;
  logic [PtrW-1:0]  waddr_q;
  logic [LostW-1:0] lost_q, lost_d;
  logic             alarm_q, alarm_d;

  logic             wen, wdata, mark_a, mark_b, is_reply, chg;
  logic [LostW-1:0] lost_drop;
  logic [ProdW-1:0] lost_prod, high_prod, low_prod;

  assign is_reply = (ctx_i.op == OpReply);
  assign wen      = is_reply ? ctx_i.reply_hit : ctx_i.ans_clr;
  assign wdata    = is_reply;

  always_ff @(posedge clk_i) begin
    if (advance_i && wen) mark_q[waddr_q] <= wdata;
    if (accept_i) begin
      rd_a_q  <= mark_q[addr_a_i];
      rd_b_q  <= mark_q[addr_b_i];
      // the event now retiring writes at this same edge: forward its mark
      hit_a_q <= advance_i && wen && (waddr_q == addr_a_i);
      hit_b_q <= advance_i && wen && (waddr_q == addr_b_i);
      fwd_q   <= wdata;
      waddr_q <= addr_a_i;
    end
  end

  assign mark_a = hit_a_q ? fwd_q : rd_a_q;
  assign mark_b = hit_b_q ? fwd_q : rd_b_q;

  always_comb begin
    lost_drop = lost_q;
    lost_d    = lost_q;
    if (is_reply) begin
      if (ctx_i.reply_hit && !mark_a && ctx_i.reply_aged && lost_q != '0)
        lost_d = lost_q - LostW'(1);
    end else begin
      if (ctx_i.drop_chk && !mark_a && lost_q != '0) lost_drop = lost_q - LostW'(1);
      lost_d = lost_drop;
      if (ctx_i.age_chk && !mark_b && lost_drop < LossWin) lost_d = lost_drop + LostW'(1);
    end
  end

  assign lost_prod = ProdW'(lost_d) * Pct100;
  assign high_prod = ProdW'(cfg_i.loss_high) * WinP;
  assign low_prod  = ProdW'(cfg_i.loss_low) * WinP;

  always_comb begin
    alarm_d = alarm_q;
    chg     = 1'b0;
    if (!is_reply) begin
      if (ctx_i.raise_ok && !alarm_q && cfg_i.loss_high != '0 && lost_prod > high_prod) begin
        alarm_d = 1'b1;
        chg     = 1'b1;
      end
    end else if (ctx_i.clear_ok && alarm_q && lost_prod < low_prod) begin
      alarm_d = 1'b0;
      chg     = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lost_q  <= '0;
      alarm_q <= 1'b0;
    end else if (advance_i) begin
      lost_q  <= lost_d;
      alarm_q <= alarm_d;
    end
  end

  assign lost_o          = LostOutW'(lost_d);
  assign alarm_o.active  = alarm_d;
  assign alarm_o.changed = chg;

  a_lost_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lost_q <= LossWin)
    else $error("lost count beyond loss window");

endmodule

// ===== design/plmon_delay.sv =====
`timescale 1ns / 1ps
// Delay sample memory, running delay sum and delay alarm with hysteresis.
module plmon_delay
  import plmon_pkg::*;
#(
  parameter int DELAY_WINDOW = 20,
  localparam int DSlotW = $clog2(DELAY_WINDOW),
  localparam int SumW   = DlyW + $clog2(DELAY_WINDOW)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic               advance_i,
  input  logic [DSlotW-1:0]  addr_i,
  input  ctx_t               ctx_i,
  input  cfg_t               cfg_i,
  output logic [SumOutW-1:0] sum_o,
  output alarm_t             alarm_o
);

  localparam logic [SumW-1:0] WinS = SumW'(DELAY_WINDOW);

  logic [DlyW-1:0]   ring_q [DELAY_WINDOW];
  logic [DlyW-1:0]   rd_q, fwd_q;
  logic              hit_q;
  logic [DSlotW-1:0] waddr_q;
  logic [SumW-1:0]   total_q, total_d;
  logic              alarm_q, alarm_d;

  logic              wen, chg;
  logic [DlyW-1:0]   old;
  logic [SumW-1:0]   high_sum, low_sum;

  assign wen = (ctx_i.op == OpReply);

  always_ff @(posedge clk_i) begin
    if (advance_i && wen) ring_q[waddr_q] <= ctx_i.delay_us;
    if (accept_i) begin
      rd_q    <= ring_q[addr_i];
      hit_q   <= advance_i && wen && (waddr_q == addr_i);
      fwd_q   <= ctx_i.delay_us;
      waddr_q <= addr_i;
    end
  end

  // slots not yet filled since reset count as zero
  assign old      = ctx_i.ring_empty ? '0 : (hit_q ? fwd_q : rd_q);
  assign total_d  = wen ? total_q + SumW'(ctx_i.delay_us) - SumW'(old) : total_q;
  assign high_sum = SumW'(cfg_i.delay_high) * WinS;
  assign low_sum  = SumW'(cfg_i.delay_low) * WinS;

  always_comb begin
    alarm_d = alarm_q;
    chg     = 1'b0;
    if (wen && ctx_i.delay_armed) begin
      if (cfg_i.delay_high != '0 && !alarm_q && total_d > high_sum) begin
        alarm_d = 1'b1;
        chg     = 1'b1;
      end else if (cfg_i.delay_low != '0 && alarm_q && total_d < low_sum) begin
        alarm_d = 1'b0;
        chg     = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      alarm_q <= 1'b0;
    end else if (advance_i) begin
      total_q <= total_d;
      alarm_q <= alarm_d;
    end
  end

  assign sum_o           = SumOutW'(total_d);
  assign alarm_o.active  = alarm_d;
  assign alarm_o.changed = chg;

  a_sent_keeps_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && ctx_i.op == OpSent |=> $stable(total_q))
    else $error("delay sum moved on a sent event");

endmodule

// ===== design/probe_loss_delay_monitor.sv =====
`timescale 1ns / 1ps
// Top level of the probe loss and delay monitor: handshake, update stage, result register.
// Staging: an accepted event waits in the update stage, its result in the result register.
// Throughput: one event per cycle while results are taken; the answered-mark and delay
//   memories forward the retiring write, so consecutive events to one slot do not stall.
// Reset: counters, sums, lost count, alarms and thresholds clear at once; the memories are
//   not swept, unwritten slots are masked by the reply count and the probe count.
module probe_loss_delay_monitor
  import plmon_pkg::*;
#(
  parameter int DELAY_WINDOW = 20,
  parameter int LOSS_HOLDOFF = 3,
  parameter int LOSS_WINDOW  = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [AddrW-1:0]   paddr,
  input  logic [DataW-1:0]   pwdata,
  output logic [DataW-1:0]   prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               operation_i,
  input  logic [SeqW-1:0]    reply_seq_i,
  input  logic [DlyW-1:0]    delay_us_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [SeqW-1:0]    probe_seq_o,
  output logic               down_alarm_o,
  output logic               delay_alarm_o,
  output logic               loss_alarm_o,
  output logic               down_changed_o,
  output logic               delay_changed_o,
  output logic               loss_changed_o,
  output logic [SumOutW-1:0] delay_window_sum_o,
  output logic [LostOutW-1:0] lost_recent_o
);

  localparam int Ring   = LOSS_HOLDOFF + LOSS_WINDOW;
  localparam int PtrW   = $clog2(Ring);
  localparam int DSlotW = $clog2(DELAY_WINDOW);

  cfg_t              cfg;
  ctx_t              ctx_d, ctx_q;
  logic [PtrW-1:0]   ans_addr_a, ans_addr_b;
  logic [DSlotW-1:0] dly_addr;
  logic              accept, advance;
  logic              s1_valid_q, s1_valid_d;
  logic              out_valid_q, out_valid_d;
  logic              down_q, down_d, down_chg;
  alarm_t            loss_al, delay_al;
  logic [LostOutW-1:0] lost;
  logic [SumOutW-1:0]  dsum;

  logic [SeqW-1:0]     seq_out_q;
  logic                down_out_q, delay_out_q, loss_out_q;
  logic                down_chg_q, delay_chg_q, loss_chg_q;
  logic [SumOutW-1:0]  sum_out_q;
  logic [LostOutW-1:0] lost_out_q;

  plmon_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  plmon_front #(
    .DELAY_WINDOW (DELAY_WINDOW),
    .LOSS_HOLDOFF (LOSS_HOLDOFF),
    .LOSS_WINDOW  (LOSS_WINDOW)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .operation_i  (operation_i),
    .reply_seq_i  (reply_seq_i),
    .delay_us_i   (delay_us_i),
    .cfg_i        (cfg),
    .ctx_o        (ctx_d),
    .ans_addr_a_o (ans_addr_a),
    .ans_addr_b_o (ans_addr_b),
    .dly_addr_o   (dly_addr)
  );

  plmon_loss #(
    .LOSS_HOLDOFF (LOSS_HOLDOFF),
    .LOSS_WINDOW  (LOSS_WINDOW)
  ) u_loss (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .advance_i (advance),
    .addr_a_i  (ans_addr_a),
    .addr_b_i  (ans_addr_b),
    .ctx_i     (ctx_q),
    .cfg_i     (cfg),
    .lost_o    (lost),
    .alarm_o   (loss_al)
  );

  plmon_delay #(
    .DELAY_WINDOW (DELAY_WINDOW)
  ) u_delay (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .advance_i (advance),
    .addr_i    (dly_addr),
    .ctx_i     (ctx_q),
    .cfg_i     (cfg),
    .sum_o     (dsum),
    .alarm_o   (delay_al)
  );

  // The update stage retires whenever the result register is free or being taken.
  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;
  assign accept     = in_valid_i && in_ready_o;

  assign s1_valid_d  = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_q);
  assign out_valid_d = advance ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_comb begin
    down_d   = down_q;
    down_chg = 1'b0;
    if (ctx_q.op == OpReply) begin
      if (down_q) begin
        down_d   = 1'b0;
        down_chg = 1'b1;
      end
    end else if (ctx_q.down_trip && !down_q) begin
      down_d   = 1'b1;
      down_chg = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      down_q      <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) down_q <= down_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) ctx_q <= ctx_d;
    if (advance) begin
      seq_out_q   <= ctx_q.probe_seq;
      down_out_q  <= down_d;
      delay_out_q <= delay_al.active;
      loss_out_q  <= loss_al.active;
      down_chg_q  <= down_chg;
      delay_chg_q <= delay_al.changed;
      loss_chg_q  <= loss_al.changed;
      sum_out_q   <= dsum;
      lost_out_q  <= lost;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign probe_seq_o        = seq_out_q;
  assign down_alarm_o       = down_out_q;
  assign delay_alarm_o      = delay_out_q;
  assign loss_alarm_o       = loss_out_q;
  assign down_changed_o     = down_chg_q;
  assign delay_changed_o    = delay_chg_q;
  assign loss_changed_o     = loss_chg_q;
  assign delay_window_sum_o = sum_out_q;
  assign lost_recent_o      = lost_out_q;

  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !advance |=> s1_valid_q && $stable(ctx_q))
    else $error("pending event lost or altered in update stage");

  a_down_toggles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && down_chg |=> down_q != $past(down_q))
    else $error("down change flagged without a toggle");

  a_reply_clears_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && ctx_q.op == OpReply |=> !down_q)
    else $error("down alarm survived a reply");

endmodule

// ===== tb/plmon_checker.sv =====
`timescale 1ns / 1ps
// Checker for the probe monitor: tracks register writes, predicts each event's status, compares.
module plmon_checker
  import plmon_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel_i,
  input  logic                penable_i,
  input  logic                pwrite_i,
  input  logic                pready_i,
  input  logic [AddrW-1:0]    paddr_i,
  input  logic [DataW-1:0]    pwdata_i,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic                operation_i,
  input  logic [SeqW-1:0]     reply_seq_i,
  input  logic [DlyW-1:0]     delay_us_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic [SeqW-1:0]     probe_seq_i,
  input  logic                down_alarm_i,
  input  logic                delay_alarm_i,
  input  logic                loss_alarm_i,
  input  logic                down_changed_i,
  input  logic                delay_changed_i,
  input  logic                loss_changed_i,
  input  logic [SumOutW-1:0]  delay_window_sum_i,
  input  logic [LostOutW-1:0] lost_recent_i,
  output int unsigned         fail_count_o,
  output int unsigned         pending_o
);

  localparam int unsigned DelayWin   = 20;
  localparam int unsigned Holdoff    = 3;
  localparam int unsigned LossWin    = 10;
  localparam int unsigned LossRing   = Holdoff + LossWin;
  localparam int unsigned MaxReports = 10;

  typedef struct packed {
    logic [SeqW-1:0]     probe_seq;
    logic                down_alarm;
    logic                delay_alarm;
    logic                loss_alarm;
    logic                down_changed;
    logic                delay_changed;
    logic                loss_changed;
    logic [SumOutW-1:0]  win_sum;
    logic [LostOutW-1:0] lost;
  } status_t;

  cfg_t            cfg;
  int unsigned     sent_cnt;
  int unsigned     reply_next;
  int unsigned     reply_cnt;
  int unsigned     dly_total;
  int unsigned     dly_slot;
  int unsigned     lost_cnt;
  logic [DlyW-1:0] dly_ring [DelayWin];
  logic            answered [LossRing];
  logic            down_on, delay_on, loss_on;
  status_t         status_q [$];
  status_t         seen, want;
  int unsigned     fails;

  function automatic status_t predict_status(input op_e op, input logic [SeqW-1:0] seq,
                                             input logic [DlyW-1:0] dly);
    status_t     st;
    int unsigned s, idx, gap, unans, nxt;
    logic [DlyW-1:0] old;
    st = '0;
    if (op == OpSent) begin
      s = sent_cnt;
      sent_cnt = s + 1;
      // oldest probe leaves the ring, next one ages into the loss window
      if (s >= LossRing) begin
        idx = s % LossRing;
        if (!answered[idx] && lost_cnt > 0) lost_cnt--;
        answered[idx] = 1'b0;
      end
      if (s >= Holdoff) begin
        idx = (s - Holdoff) % LossRing;
        if (!answered[idx] && lost_cnt < LossWin) lost_cnt++;
      end
      if (s > LossRing && !loss_on && cfg.loss_high != 0 &&
          64'(lost_cnt) * 100 > 64'(cfg.loss_high) * LossWin) begin
        loss_on = 1'b1;
        st.loss_changed = 1'b1;
      end
      if (cfg.down_limit != 0 && !down_on) begin
        unans = (sent_cnt > reply_next) ? sent_cnt - reply_next : 0;
        if (unans > cfg.down_limit) begin
          down_on = 1'b1;
          st.down_changed = 1'b1;
        end
      end
    end else begin
      nxt = 32'(seq) + 1;
      if (nxt > reply_next) reply_next = nxt;
      if (down_on) begin
        down_on = 1'b0;
        st.down_changed = 1'b1;
      end

      if (dly_slot >= DelayWin) dly_slot = 0;
      old = dly_ring[dly_slot];
      dly_ring[dly_slot] = dly;
      dly_total = dly_total + dly - old;
      dly_slot = (dly_slot + 1) % DelayWin;
      if (reply_cnt != 32'hFFFF_FFFF) reply_cnt++;

      if (reply_cnt > DelayWin) begin
        if (cfg.delay_high != 0 && !delay_on &&
            64'(dly_total) > 64'(cfg.delay_high) * DelayWin) begin
          delay_on = 1'b1;
          st.delay_changed = 1'b1;
        end else if (cfg.delay_low != 0 && delay_on &&
                     64'(dly_total) < 64'(cfg.delay_low) * DelayWin) begin
          delay_on = 1'b0;
          st.delay_changed = 1'b1;
        end
      end

      if (sent_cnt != 0) begin
        gap = (sent_cnt - 1 - 32'(seq)) & 32'h7FFF_FFFF;
        if (gap < LossRing && gap < sent_cnt) begin
          idx = (sent_cnt - 1 - gap) % LossRing;
          if (!answered[idx]) begin
            // a late answer takes the probe back out of the lost count
            if (gap >= Holdoff && lost_cnt > 0) lost_cnt--;
            answered[idx] = 1'b1;
          end
        end
      end
      if (sent_cnt > LossRing + 1 && loss_on &&
          64'(lost_cnt) * 100 < 64'(cfg.loss_low) * LossWin) begin
        loss_on = 1'b0;
        st.loss_changed = 1'b1;
      end
    end

    st.probe_seq   = (sent_cnt == 0) ? '0 : SeqW'(sent_cnt - 1);
    st.down_alarm  = down_on;
    st.delay_alarm = delay_on;
    st.loss_alarm  = loss_on;
    st.win_sum     = SumOutW'(dly_total);
    st.lost        = LostOutW'(lost_cnt);
    return st;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg        = '0;
      sent_cnt   = 0;
      reply_next = 0;
      reply_cnt  = 0;
      dly_total  = 0;
      dly_slot   = 0;
      lost_cnt   = 0;
      down_on    = 1'b0;
      delay_on   = 1'b0;
      loss_on    = 1'b0;
      for (int i = 0; i < DelayWin; i++) dly_ring[i] = '0;
      for (int i = 0; i < LossRing; i++) answered[i] = 1'b0;
      status_q.delete();
      fails = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (reg_idx_e'(paddr_i[AddrW-1:2]))
          RegDownLimit: cfg.down_limit = pwdata_i[LimitW-1:0];
          RegDelayHigh: cfg.delay_high = pwdata_i[DlyW-1:0];
          RegDelayLow:  cfg.delay_low  = pwdata_i[DlyW-1:0];
          RegLossHigh:  cfg.loss_high  = pwdata_i[PctW-1:0];
          RegLossLow:   cfg.loss_low   = pwdata_i[PctW-1:0];
          default: ;
        endcase
      end

      // compare before queuing: a status never leaves in its own event's cycle
      if (out_valid_i && out_ready_i) begin
        seen = {probe_seq_i, down_alarm_i, delay_alarm_i, loss_alarm_i, down_changed_i,
                delay_changed_i, loss_changed_i, delay_window_sum_i, lost_recent_i};
        if (status_q.size() == 0) begin
          if (fails < MaxReports)
            $display("%0t: status transfer with none outstanding (seq %0d)", $time,
                     probe_seq_i);
          fails++;
        end else begin
          want = status_q.pop_front();
          if (seen !== want) begin
            if (fails < MaxReports) begin
              $display("%0t: status mismatch, expected seq %0d alarms %b%b%b changed %b%b%b sum %0d lost %0d",
                       $time, want.probe_seq, want.down_alarm, want.delay_alarm,
                       want.loss_alarm, want.down_changed, want.delay_changed,
                       want.loss_changed, want.win_sum, want.lost);
              $display("%0t:   actual seq %0d alarms %b%b%b changed %b%b%b sum %0d lost %0d",
                       $time, seen.probe_seq, seen.down_alarm, seen.delay_alarm,
                       seen.loss_alarm, seen.down_changed, seen.delay_changed,
                       seen.loss_changed, seen.win_sum, seen.lost);
            end
            fails++;
          end
        end
      end

      if (in_valid_i && in_ready_i)
        status_q.push_back(predict_status(op_e'(operation_i), reply_seq_i, delay_us_i));
    end
    fail_count_o <= fails;
    pending_o    <= status_q.size();
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench top for the probe monitor: clock, reset, register setup, event traffic, verdict.
module tb_top;
  import plmon_pkg::*;

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [AddrW-1:0]    paddr;
  logic [DataW-1:0]    pwdata;
  logic [DataW-1:0]    prdata;
  logic                pready;
  logic                in_valid_i;
  logic                in_ready_o;
  logic                operation_i;
  logic [SeqW-1:0]     reply_seq_i;
  logic [DlyW-1:0]     delay_us_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [SeqW-1:0]     probe_seq_o;
  logic                down_alarm_o;
  logic                delay_alarm_o;
  logic                loss_alarm_o;
  logic                down_changed_o;
  logic                delay_changed_o;
  logic                loss_changed_o;
  logic [SumOutW-1:0]  delay_window_sum_o;
  logic [LostOutW-1:0] lost_recent_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned probes_sent;
  int unsigned events_sent;
  int unsigned dly_center;
  bit          dly_slow;
  bit          calm;
  bit          wide_seq;

  probe_loss_delay_monitor dut (.*);

  plmon_checker checker_i (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .psel_i             (psel),
    .penable_i          (penable),
    .pwrite_i           (pwrite),
    .pready_i           (pready),
    .paddr_i            (paddr),
    .pwdata_i           (pwdata),
    .in_valid_i         (in_valid_i),
    .in_ready_i         (in_ready_o),
    .operation_i        (operation_i),
    .reply_seq_i        (reply_seq_i),
    .delay_us_i         (delay_us_i),
    .out_valid_i        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .probe_seq_i        (probe_seq_o),
    .down_alarm_i       (down_alarm_o),
    .delay_alarm_i      (delay_alarm_o),
    .loss_alarm_i       (loss_alarm_o),
    .down_changed_i     (down_changed_o),
    .delay_changed_i    (delay_changed_o),
    .loss_changed_i     (loss_changed_o),
    .delay_window_sum_i (delay_window_sum_o),
    .lost_recent_i      (lost_recent_o),
    .fail_count_o       (fail_count),
    .pending_o          (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(2_000_000);
    $display("Some tests failed");
    $finish;
  end

  task automatic cfg_write(input reg_idx_e idx, input logic [DataW-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apply_settings(input logic [LimitW-1:0] down, input logic [DlyW-1:0] dly_hi,
                                input logic [DlyW-1:0] dly_lo, input logic [PctW-1:0] loss_hi,
                                input logic [PctW-1:0] loss_lo);
    cfg_write(RegDownLimit, DataW'(down));
    cfg_write(RegDelayHigh, DataW'(dly_hi));
    cfg_write(RegDelayLow, DataW'(dly_lo));
    cfg_write(RegLossHigh, DataW'(loss_hi));
    cfg_write(RegLossLow, DataW'(loss_lo));
  endtask

  // valid stays high across back-to-back transfers; drop it only for a gap
  task automatic send_event(input op_e op, input logic [SeqW-1:0] seq,
                            input logic [DlyW-1:0] dly);
    while (!calm && $urandom_range(99) < 19) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    reply_seq_i <= seq;
    delay_us_i  <= dly;
    do @(posedge clk_i); while (!in_ready_o);
    events_sent++;
    if (op == OpSent) probes_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  function automatic logic [DlyW-1:0] next_delay();
    int unsigned base;
    if ($urandom_range(99) < 4) return DlyW'($urandom);
    base = dly_slow ? dly_center + dly_center / 2 : dly_center / 2;
    return DlyW'(base + $urandom_range(0, dly_center / 2));
  endfunction

  // one probe, usually answered, plus occasional late, duplicate, stray or outage traffic
  task automatic probe_round(input int unsigned answer_pct);
    int unsigned r;
    send_event(OpSent, SeqW'($urandom), DlyW'($urandom));
    if ($urandom_range(99) < 5) dly_slow = !dly_slow;
    if ($urandom_range(99) < answer_pct)
      send_event(OpReply, SeqW'(probes_sent - 1), next_delay());
    r = $urandom_range(99);
    if (r < 8) begin
      if (probes_sent > 15)
        send_event(OpReply, SeqW'(probes_sent - 1 - $urandom_range(1, 14)), next_delay());
    end else if (r < 11) begin
      send_event(OpReply, SeqW'(probes_sent - 1), next_delay());
    end else if (r < 13) begin
      send_event(OpReply, wide_seq ? SeqW'($urandom) :
                 SeqW'($urandom_range(0, probes_sent + 20)), next_delay());
    end else if (r < 14) begin
      send_event(OpReply, SeqW'(probes_sent + $urandom_range(0, 3)), next_delay());
    end else if (r < 16) begin
      repeat ($urandom_range(4, 16)) send_event(OpSent, SeqW'($urandom), DlyW'($urandom));
    end
  endtask

  // receiver: random stalls, plus one long hold-off to back the block up
  initial begin : receiver
    int unsigned results_seen;
    int unsigned hold_left;
    bit          held;
    results_seen = 0;
    hold_left    = 0;
    held         = 1'b0;
    out_ready_i  = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) results_seen++;
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (!held && results_seen >= 700) begin
        held        = 1'b1;
        hold_left   = 150;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= calm || $urandom_range(99) >= 19;
      end
    end
  end

  initial begin : stimulus
    int unsigned loss_hi;
    int unsigned answer_pct;
    int unsigned target;
    rst_ni      = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    in_valid_i  = 1'b0;
    operation_i = OpSent;
    reply_seq_i = '0;
    delay_us_i  = '0;
    probes_sent = 0;
    events_sent = 0;
    dly_center  = 1000;
    dly_slow    = 1'b0;
    calm        = 1'b0;
    wide_seq    = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: down alarm, loss warm-up, duplicate, late and out-of-range replies
    apply_settings(16'd3, 24'hFF_FFFF, 24'd1, 7'd1, 7'd100);
    send_event(OpReply, '0, '0);
    repeat (5) send_event(OpSent, '1, '1);
    send_event(OpReply, 31'd2, '1);
    repeat (10) send_event(OpSent, '0, '0);
    send_event(OpReply, 31'd14, 24'd500);
    send_event(OpReply, 31'd14, 24'd500);
    send_event(OpReply, 31'd10, 24'd1);
    send_event(OpReply, 31'd3, 24'd2);
    send_event(OpReply, 31'd0, '1);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          dly_center = 2000;
          apply_settings(16'd1, 24'd2500, '0, 7'd100, '0);
        end
        1: begin
          dly_center = $urandom_range(16, 1 << 22);
          apply_settings(16'hFFFF, '1, '1, 7'd1, 7'd100);
        end
        2: apply_settings('0, '0, '0, '0, '0);
        default: begin
          dly_center = $urandom_range(16, 1 << 22);
          loss_hi    = $urandom_range(1, 100);
          apply_settings(LimitW'($urandom_range(1, 12)),
                         DlyW'(dly_center + dly_center / 4),
                         DlyW'(dly_center - dly_center / 8),
                         PctW'(loss_hi), PctW'($urandom_range(0, loss_hi)));
        end
      endcase
      calm       = (ph == 3);
      wide_seq   = (ph == 5);
      answer_pct = $urandom_range(40, 95);
      target     = events_sent + 258;
      while (events_sent < target) probe_round(answer_pct);
      drain();
    end
    calm = 1'b0;

    // highest sequence last: it blinds the down check from here on
    send_event(OpReply, '1, '1);
    drain();

    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/plmon_pkg.sv
design/plmon_cfg.sv
design/plmon_front.sv
design/plmon_loss.sv
design/plmon_delay.sv
design/probe_loss_delay_monitor.sv
tb/plmon_checker.sv
tb/tb_top.sv
